// ===== rtl/pt2s_pkg.sv =====
package pt2s_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int VP_WIDTH = 13;
    localparam logic [VP_WIDTH-1:0] VP_WIDTH_RESET  = 13'd320;
    localparam logic [VP_WIDTH-1:0] VP_HEIGHT_RESET = 13'd240;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VIEWPORT_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VIEWPORT_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD_MODELVIEW  = 2'd0,
        OP_LOAD_PROJECTION = 2'd1,
        OP_PROJECT         = 2'd2
    } opcode_t;

    typedef struct packed {
        opcode_t            op;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_XFORM,
        BK_DIV,
        BK_MAP,
        BK_OUT
    } back_state_t;

endpackage

// ===== rtl/point_to_screen_projection.sv =====
// Projects object-space points to viewport coordinates through a stored modelview
// and projection matrix (column-major, element c*4+r), all values signed fixed point
// with FRAC_BITS fraction bits. Opcode 0 and 1 load one matrix element, opcode 2
// projects a point and returns one result; opcode 3 is accepted and dropped. Inputs
// land in a two-entry queue, so the port keeps taking items while the back end works,
// until the queue is full; the back end takes a new item only when idle. A load
// writes its element in the back end. A projection is taken from the queue, runs 32
// multiply-accumulates through one shared 32x32 multiplier, loads the dividers, runs
// three parallel restoring dividers retiring one quotient bit per cycle, then maps
// the quotients and, once the output register is free, applies the viewport scale
// as the result is registered. A zero clip w skips the divide and returns
// projected_ok low with all coordinates zero. The viewport registers reset to
// 320 by 240 and should be written only while the block is idle.
module point_to_screen_projection #(
    parameter int FRAC_BITS = pt2s_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               projected_ok,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic signed [31:0] depth
);

    logic [12:0]     vp_width_reg, vp_width_next;
    logic [12:0]     vp_height_reg, vp_height_next;
    logic            q_full;
    logic            push;
    pt2s_pkg::item_t push_item;
    logic            q_valid;
    logic            q_ready;
    pt2s_pkg::item_t q_item;

    always_comb
    begin
        vp_width_next  = vp_width_reg;
        vp_height_next = vp_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pt2s_pkg::REG_VIEWPORT_WIDTH:  vp_width_next  = cfg_data;
                pt2s_pkg::REG_VIEWPORT_HEIGHT: vp_height_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_width_reg  <= pt2s_pkg::VP_WIDTH_RESET;
            vp_height_reg <= pt2s_pkg::VP_HEIGHT_RESET;
        end
        else
        begin
            vp_width_reg  <= vp_width_next;
            vp_height_reg <= vp_height_next;
        end
    end

    pt2s_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .element_index (element_index),
        .element_value (element_value),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    pt2s_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_item  (q_item)
    );

    pt2s_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .vp_width     (vp_width_reg),
        .vp_height    (vp_height_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .projected_ok (projected_ok),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .depth        (depth)
    );

endmodule

// ===== rtl/pt2s_front.sv =====
module pt2s_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               q_full,
    output logic               push,
    output pt2s_pkg::item_t    push_item
);

    logic known_op;

    assign in_ready = !q_full;

    // the unused opcode is accepted and dropped here
    assign known_op = (opcode == pt2s_pkg::OP_LOAD_MODELVIEW)
                   || (opcode == pt2s_pkg::OP_LOAD_PROJECTION)
                   || (opcode == pt2s_pkg::OP_PROJECT);

    assign push = in_valid && in_ready && known_op;

    always_comb
    begin
        push_item.op            = pt2s_pkg::opcode_t'(opcode);
        push_item.element_index = element_index;
        push_item.element_value = element_value;
        push_item.point_x       = point_x;
        push_item.point_y       = point_y;
        push_item.point_z       = point_z;
    end

endmodule

// ===== rtl/pt2s_queue.sv =====
module pt2s_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pt2s_pkg::item_t push_item,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop_ready,
    output pt2s_pkg::item_t pop_item
);

    pt2s_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/pt2s_back.sv =====
module pt2s_back #(
    parameter int FRAC_BITS = pt2s_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  pt2s_pkg::item_t    q_item,
    input  logic [12:0]        vp_width,
    input  logic [12:0]        vp_height,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               projected_ok,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic signed [31:0] depth
);

    localparam int DW  = 32 + FRAC_BITS;
    localparam int DCW = $clog2(DW);
    localparam logic [DCW-1:0] DLAST = DCW'(DW - 1);
    localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HLIM  = 64'sd1 <<< 40;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic signed [41:0] clamp_h(input logic signed [63:0] v);
        if (v > HLIM)
            clamp_h = HLIM[41:0];
        else if (v < -HLIM)
            clamp_h = 42'(-HLIM);
        else
            clamp_h = v[41:0];
    endfunction

    pt2s_pkg::back_state_t state_reg, state_next;

    logic signed [31:0] mv_reg [16], mv_next [16];
    logic signed [31:0] pr_reg [16], pr_next [16];
    logic signed [31:0] pt_reg [3],  pt_next [3];
    logic signed [31:0] e_reg [4],   e_next [4];
    logic signed [31:0] c_reg [4],   c_next [4];

    logic               pass_reg, pass_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               prod_vld_reg, prod_vld_next;
    logic [1:0]         prod_row_reg, prod_row_next;
    logic               prod_last_reg, prod_last_next;
    logic signed [63:0] acc_reg, acc_next;

    logic [DW-1:0]      num_reg [3], num_next [3];
    logic [31:0]        rem_reg [3], rem_next [3];
    logic               neg_reg [3], neg_next [3];
    logic [31:0]        den_reg, den_next;
    logic [DCW-1:0]     dcnt_reg, dcnt_next;

    logic               ok_reg, ok_next;
    logic signed [41:0] h_reg [3], h_next [3];

    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic signed [31:0] out_x_reg, out_x_next;
    logic signed [31:0] out_y_reg, out_y_next;
    logic signed [31:0] out_z_reg, out_z_next;

    logic [1:0]         col, row;
    logic signed [31:0] m_sel, v_sel;
    logic signed [63:0] term_sum;
    logic [32:0]        trial [3];
    logic               ge [3];
    logic [31:0]        rem_step [3];
    logic [DW-1:0]      num_step [3];
    logic signed [63:0] ndc [3];
    logic signed [63:0] half [3];
    logic signed [63:0] scaled_x, scaled_y;

    assign col = cnt_reg[1:0];
    assign row = cnt_reg[3:2];

    always_comb
    begin
        m_sel = pass_reg ? pr_reg[{col, row}] : mv_reg[{col, row}];
        if (pass_reg)
            v_sel = e_reg[col];
        else if (col == 2'd3)
            v_sel = ONE32;
        else
            v_sel = pt_reg[col];
    end

    assign prod_next = m_sel * v_sel;
    assign term_sum  = acc_reg + (prod_reg >>> FRAC_BITS);

    // one restoring divide step per lane, all lanes share the divisor |w|
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        assign trial[i]    = {rem_reg[i], num_reg[i][DW-1]};
        assign ge[i]       = (trial[i] >= {1'b0, den_reg});
        assign rem_step[i] = ge[i] ? 32'(trial[i] - {1'b0, den_reg}) : trial[i][31:0];
        assign num_step[i] = {num_reg[i][DW-2:0], ge[i]};
        assign ndc[i]      = neg_reg[i] ? -$signed(64'(num_reg[i])) : $signed(64'(num_reg[i]));
        assign half[i]     = (ndc[i] + ONE) >>> 1;
    end

    assign scaled_x = h_reg[0] * $signed({1'b0, vp_width});
    assign scaled_y = h_reg[1] * $signed({1'b0, vp_height});

    always_comb
    begin
        state_next     = state_reg;
        mv_next        = mv_reg;
        pr_next        = pr_reg;
        pt_next        = pt_reg;
        e_next         = e_reg;
        c_next         = c_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        prod_vld_next  = 1'b0;
        prod_row_next  = row;
        prod_last_next = (col == 2'd3);
        acc_next       = acc_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        den_next       = den_reg;
        dcnt_next      = dcnt_reg;
        ok_next        = ok_reg;
        h_next         = h_reg;
        q_ready        = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_ok_next    = out_ok_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;

        unique case (state_reg)
            pt2s_pkg::BK_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    unique case (q_item.op)
                        pt2s_pkg::OP_LOAD_MODELVIEW:
                            mv_next[q_item.element_index] = q_item.element_value;
                        pt2s_pkg::OP_LOAD_PROJECTION:
                            pr_next[q_item.element_index] = q_item.element_value;
                        pt2s_pkg::OP_PROJECT:
                        begin
                            pt_next[0] = q_item.point_x;
                            pt_next[1] = q_item.point_y;
                            pt_next[2] = q_item.point_z;
                            pass_next  = 1'b0;
                            cnt_next   = 5'd0;
                            acc_next   = '0;
                            state_next = pt2s_pkg::BK_XFORM;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            pt2s_pkg::BK_XFORM:
            begin
                // multiply one element per cycle, accumulate the registered product in the next cycle
                prod_vld_next = !cnt_reg[4];
                if (prod_vld_reg)
                begin
                    if (prod_last_reg)
                    begin
                        acc_next = '0;
                        if (pass_reg)
                            c_next[prod_row_reg] = sat32(term_sum);
                        else
                            e_next[prod_row_reg] = sat32(term_sum);
                    end
                    else
                    begin
                        acc_next = term_sum;
                    end
                end
                if (cnt_reg[4])
                begin
                    cnt_next = 5'd0;
                    if (!pass_reg)
                        pass_next = 1'b1;
                    else
                        state_next = pt2s_pkg::BK_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end

            pt2s_pkg::BK_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    // load the dividers or report a zero clip w
                    cnt_next  = 5'd1;
                    dcnt_next = '0;
                    den_next  = c_reg[3][31] ? 32'(-c_reg[3]) : 32'(c_reg[3]);
                    for (int i = 0; i < 3; i++)
                    begin
                        num_next[i] = {(c_reg[i][31] ? 32'(-c_reg[i]) : 32'(c_reg[i])),
                                       {FRAC_BITS{1'b0}}};
                        rem_next[i] = '0;
                        neg_next[i] = c_reg[i][31] ^ c_reg[3][31];
                    end
                    if (c_reg[3] == '0)
                    begin
                        ok_next    = 1'b0;
                        state_next = pt2s_pkg::BK_OUT;
                    end
                    else
                    begin
                        ok_next = 1'b1;
                    end
                end
                else
                begin
                    num_next  = num_step;
                    rem_next  = rem_step;
                    dcnt_next = dcnt_reg + DCW'(1);
                    if (dcnt_reg == DLAST)
                        state_next = pt2s_pkg::BK_MAP;
                end
            end

            pt2s_pkg::BK_MAP:
            begin
                for (int i = 0; i < 3; i++)
                    h_next[i] = clamp_h(half[i]);
                state_next = pt2s_pkg::BK_OUT;
            end

            pt2s_pkg::BK_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_x_next     = ok_reg ? sat32(scaled_x) : '0;
                    out_y_next     = ok_reg ? sat32(scaled_y) : '0;
                    out_z_next     = ok_reg ? sat32(64'(h_reg[2])) : '0;
                    cnt_next       = 5'd0;
                    state_next     = pt2s_pkg::BK_IDLE;
                end
            end

            default:
                state_next = pt2s_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pt2s_pkg::BK_IDLE;
            pass_reg      <= 1'b0;
            cnt_reg       <= 5'd0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                mv_reg[i] <= (i % 5 == 0) ? ONE32 : '0;
                pr_reg[i] <= (i % 5 == 0) ? ONE32 : '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            prod_vld_reg  <= prod_vld_next;
            out_valid_reg <= out_valid_next;
            mv_reg        <= mv_next;
            pr_reg        <= pr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg        <= pt_next;
        e_reg         <= e_next;
        c_reg         <= c_next;
        prod_reg      <= prod_next;
        prod_row_reg  <= prod_row_next;
        prod_last_reg <= prod_last_next;
        acc_reg       <= acc_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        den_reg       <= den_next;
        dcnt_reg      <= dcnt_next;
        ok_reg        <= ok_next;
        h_reg         <= h_next;
        out_ok_reg    <= out_ok_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_z_reg     <= out_z_next;
    end

    assign out_valid    = out_valid_reg;
    assign projected_ok = out_ok_reg;
    assign screen_x     = out_x_reg;
    assign screen_y     = out_y_reg;
    assign depth        = out_z_reg;

endmodule

// ===== rtl/pt2s_checker.sv =====
module pt2s_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               projected_ok,
    input logic signed [31:0] screen_x,
    input logic signed [31:0] screen_y,
    input logic signed [31:0] depth
);

    // no transaction can be offered while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // a failed projection carries zero coordinates
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !projected_ok |-> screen_x == 0 && screen_y == 0 && depth == 0)
        else $error("failed projection with nonzero coordinates");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
            && $stable(depth) && $stable(projected_ok))
        else $error("stalled result changed");

endmodule

bind point_to_screen_projection pt2s_checker u_pt2s_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .projected_ok (projected_ok),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .depth        (depth)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint UNITY = 64'sd65536;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } vec_item_t;

    typedef struct {
        logic        ok;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] dp;
    } screen_pt_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [12:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               out_valid;
    logic               out_ready;
    logic               projected_ok;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;

    point_to_screen_projection dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .element_index(element_index), .element_value(element_value),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .projected_ok(projected_ok), .screen_x(screen_x), .screen_y(screen_y),
        .depth(depth)
    );

    // predictor state
    longint     mv_mat[16];
    longint     pj_mat[16];
    logic [12:0] vp_w;
    logic [12:0] vp_h;

    vec_item_t  pending_q[$];
    screen_pt_t screen_q[$];
    int         err_count;
    int         sent_count;
    int         result_count;
    int         zero_w_count;
    longint     cycle_count;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void mat_vec(input longint m[16], input longint v[4],
                                    output longint o[4]);
        longint acc;
        for (int r = 0; r < 4; r++)
        begin
            acc = 0;
            for (int c = 0; c < 4; c++)
                acc += (m[c*4+r] * v[c]) >>> 16;
            o[r] = sat32(acc);
        end
    endfunction

    function automatic longint scale_view(longint half, logic [12:0] size);
        longint lim;
        lim = 64'sd1 <<< 40;
        if (size == 0)
            return 0;
        if (half > lim)
            half = lim;
        if (half < -lim)
            half = -lim;
        return sat32(half * longint'(size));
    endfunction

    // applies one accepted transaction to the predictor
    task automatic project_or_load(input vec_item_t it);
        longint     p[4];
        longint     e[4];
        longint     c[4];
        longint     h[3];
        longint     ndc;
        screen_pt_t res;
        if (it.op == pt2s_pkg::OP_LOAD_MODELVIEW)
            mv_mat[it.idx] = longint'($signed(it.val));
        else if (it.op == pt2s_pkg::OP_LOAD_PROJECTION)
            pj_mat[it.idx] = longint'($signed(it.val));
        else if (it.op == pt2s_pkg::OP_PROJECT)
        begin
            p[0] = longint'($signed(it.px));
            p[1] = longint'($signed(it.py));
            p[2] = longint'($signed(it.pz));
            p[3] = UNITY;
            mat_vec(mv_mat, p, e);
            mat_vec(pj_mat, e, c);
            if (c[3] == 0)
            begin
                res = '{1'b0, 32'd0, 32'd0, 32'd0};
                zero_w_count++;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ndc = (c[i] * UNITY) / c[3];
                    h[i] = (ndc + UNITY) >>> 1;
                end
                res.ok = 1'b1;
                res.sx = 32'(scale_view(h[0], vp_w));
                res.sy = 32'(scale_view(h[1], vp_h));
                res.dp = 32'(sat32(h[2]));
            end
            screen_q.push_back(res);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom();
        if (sel < 3)
            return 32'($signed($urandom_range(0, 2097152)) - 1048576);
        return 32'($signed($urandom_range(0, 1310720)) - 655360);
    endfunction

    function automatic vec_item_t make_item();
        vec_item_t it;
        int sel;
        it.op = pt2s_pkg::OP_PROJECT;
        it.idx = 4'($urandom());
        it.val = $urandom();
        it.px = rand_coord();
        it.py = rand_coord();
        it.pz = rand_coord();
        sel = $urandom_range(0, 99);
        if (sel < 25)
        begin
            it.op = (sel < 12) ? pt2s_pkg::OP_LOAD_MODELVIEW : pt2s_pkg::OP_LOAD_PROJECTION;
            // mostly modest matrix entries so w stays usable
            if (sel % 4 != 0)
                it.val = 32'($signed($urandom_range(0, 262144)) - 131072);
        end
        else if (sel < 28)
        begin
            // zero one entry of the w row, sometimes leading to zero clip w
            it.op = pt2s_pkg::OP_LOAD_PROJECTION;
            it.idx = 4'($urandom_range(0, 3) * 4 + 3);
            it.val = 32'd0;
        end
        else if (sel < 30)
        begin
            // restore w row entry to keep projections meaningful
            it.op = pt2s_pkg::OP_LOAD_PROJECTION;
            it.idx = 4'd15;
            it.val = 32'h0001_0000;
        end
        else if (sel < 33)
            it.op = OP_UNUSED;
        return it;
    endfunction

    function automatic vec_item_t mk(logic [1:0] op, logic [3:0] idx, logic [31:0] val,
                                     logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        vec_item_t it;
        it = '{op, idx, val, px, py, pz};
        return it;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == pt2s_pkg::REG_VIEWPORT_WIDTH)
            vp_w = data;
        else if (idx == pt2s_pkg::REG_VIEWPORT_HEIGHT)
            vp_h = data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_quiet();
        wait (pending_q.size() == 0 && !in_valid && screen_q.size() == 0);
        // loads produce nothing, so give the back end time to finish
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            pending_q.push_back(make_item());
        wait_quiet();
    endtask

    // sender: bursts with random gaps
    int        burst_left;
    int        gap_left;
    vec_item_t on_port;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                project_or_load(on_port);
                sent_count++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    on_port = pending_q.pop_front();
                    opcode <= on_port.op;
                    element_index <= on_port.idx;
                    element_value <= on_port.val;
                    point_x <= on_port.px;
                    point_y <= on_port.py;
                    point_z <= on_port.pz;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    int  hold_left;
    bit  hold_done;
    int  stall_mode;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_done = 0;
            stall_mode = 0;
        end
        else
        begin
            if (!hold_done && sent_count >= 150)
            begin
                hold_done = 1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if ($urandom_range(0, 199) == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_mode == 0)
                out_ready <= 1'b1;
            else if (stall_mode == 1)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        screen_pt_t exp_pt;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (screen_q.size() == 0)
            begin
                $error("unexpected result transaction");
                err_count++;
            end
            else
            begin
                exp_pt = screen_q.pop_front();
                if (projected_ok !== exp_pt.ok)
                begin
                    $error("projected_ok: expected %0d got %0d", exp_pt.ok, projected_ok);
                    err_count++;
                end
                if (screen_x !== exp_pt.sx)
                begin
                    $error("screen_x: expected %0d got %0d", $signed(exp_pt.sx), screen_x);
                    err_count++;
                end
                if (screen_y !== exp_pt.sy)
                begin
                    $error("screen_y: expected %0d got %0d", $signed(exp_pt.sy), screen_y);
                    err_count++;
                end
                if (depth !== exp_pt.dp)
                begin
                    $error("depth: expected %0d got %0d", $signed(exp_pt.dp), depth);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = '0;
        element_index = '0;
        element_value = '0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        out_ready = 1'b0;
        err_count = 0;
        sent_count = 0;
        result_count = 0;
        zero_w_count = 0;
        cycle_count = 0;
        for (int i = 0; i < 16; i++)
        begin
            mv_mat[i] = (i % 5 == 0) ? UNITY : 0;
            pj_mat[i] = (i % 5 == 0) ? UNITY : 0;
        end
        vp_w = pt2s_pkg::VP_WIDTH_RESET;
        vp_h = pt2s_pkg::VP_HEIGHT_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: identity transforms, extremes, unused opcode, zero w
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h0001_0000, 32'hFFFF_0000,
                               32'h0000_8000));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000));
        pending_q.push_back(mk(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF));
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_PROJECTION, 15, 0, 0, 0, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h0002_0000, 32'h0003_0000,
                               32'h0001_0000));
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_PROJECTION, 15, 32'h0001_0000, 0, 0, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_MODELVIEW, 0, 32'h7FFF_FFFF, 0, 0, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h7FFF_FFFF, 32'h0001_0000, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_MODELVIEW, 0, 32'h8000_0000, 0, 0, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h7FFF_FFFF, 32'h0001_0000, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_MODELVIEW, 0, 32'h0001_0000, 0, 0, 0));
        // perspective-like w row: w = -z
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_PROJECTION, 11, 32'hFFFF_0000, 0, 0, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_PROJECTION, 15, 0, 0, 0, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h0000_8000, 32'hFFFF_8000,
                               32'hFFFE_0000));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h0001_0000, 32'h0001_0000, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_PROJECT, 0, 0, 32'h0000_0001, 32'h0000_0000,
                               32'h0000_0001));
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_PROJECTION, 11, 0, 0, 0, 0));
        pending_q.push_back(mk(pt2s_pkg::OP_LOAD_PROJECTION, 15, 32'h0001_0000, 0, 0, 0));
        wait_quiet();

        run_random(300);
        write_reg(pt2s_pkg::REG_VIEWPORT_WIDTH, 13'd1);
        write_reg(pt2s_pkg::REG_VIEWPORT_HEIGHT, 13'd1);
        run_random(150);
        write_reg(pt2s_pkg::REG_VIEWPORT_WIDTH, 13'd4096);
        write_reg(pt2s_pkg::REG_VIEWPORT_HEIGHT, 13'd4096);
        run_random(150);
        write_reg(pt2s_pkg::REG_VIEWPORT_WIDTH, 13'd0);
        write_reg(pt2s_pkg::REG_VIEWPORT_HEIGHT, 13'd8191);
        write_reg(2'd2, 13'h1FFF);
        write_reg(2'd3, 13'h0AAA);
        run_random(150);
        write_reg(pt2s_pkg::REG_VIEWPORT_WIDTH, 13'($urandom()));
        write_reg(pt2s_pkg::REG_VIEWPORT_HEIGHT, 13'($urandom_range(1, 4096)));
        run_random(150);

        $display("sent %0d transactions, checked %0d results (%0d with zero clip w)",
                 sent_count, result_count, zero_w_count);
        $display("viewport settings covered 1, 4096, 0, 8191 and random values");
        if (err_count == 0 && screen_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
